// File: rtl/core/tcr_pkg.sv
`default_nettype none

package tcr_pkg;

	typedef enum logic [2:0] {
		KIND_UNKNOWN = 3'd0,
		KIND_SET     = 3'd1,
		KIND_DELETE  = 3'd2,
		KIND_VERIFY  = 3'd3,
		KIND_LIST    = 3'd4,
		KIND_INFO    = 3'd5,
		KIND_CLEAR   = 3'd6
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  user_id;
	} tcr_result_t;

	localparam int NUM_KW = 6;

	// Keyword text, first character in the lowest byte, zero padded to eight bytes.
	// Row order matches the command kinds: SET, DEL, VERIFY, LIST, INFO, CLEAR.
	localparam logic [NUM_KW-1:0][63:0] KW_TEXT = {
		{24'd0, "RAELC"},
		{32'd0, "OFNI"},
		{32'd0, "TSIL"},
		{16'd0, "YFIREV"},
		{40'd0, "LED"},
		{40'd0, "TES"}
	};

	localparam logic [NUM_KW-1:0][2:0] KW_LEN = {3'd5, 3'd4, 3'd4, 3'd6, 3'd3, 3'd3};

	// "ID:" with the first character in the lowest byte
	localparam logic [31:0] ID_PREFIX = {8'd0, ":DI"};

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'h20;

endpackage

`default_nettype wire

// File: rtl/core/text_command_recognizer.sv
// Streaming command-line recognizer.
// Slave side: one text byte per beat on s_tdata, s_tlast marks the final byte
// of a command line. Master side: one result beat per line, carrying the
// command kind and the user id parsed from an "ID:" token.
// The result is registered and appears on m_tvalid in the cycle after the s_tlast beat.
// Throughput: one byte per cycle while s_tready is high; the parser state is updated
// once per beat, the result register once per line, so back-to-back bytes and lines are fine.
// Bytes beyond the first MAX_LEN-1 of a line and bytes after a zero byte are
// absorbed without effect.
// Reset (arst_n low) empties the result register and returns the parser to
// the start of a line.
// When the master side stalls, the result is held and s_tready drops only
// while a held result is not being taken in the same cycle.
`default_nettype none

module text_command_recognizer #(
	parameter int MAX_LEN = 128
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] char_code
	input  wire logic         s_tlast,   // end_of_string
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [15:0]       m_tdata    // [2:0] command_kind, [10:3] user_id, [15:11] zero
);
	import tcr_pkg::*;

	logic         take;
	logic         res_valid;
	logic         free;
	tcr_result_t  result;
	tcr_result_t  held;

	assign s_tready = free;
	assign take = s_tvalid && free;

	tcr_parser #(
		.MAX_LEN(MAX_LEN)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.char_code     (s_tdata),
		.end_of_string (s_tlast),
		.res_valid     (res_valid),
		.result        (result)
	);

	tcr_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_valid),
		.result (result),
		.free   (free),
		.valid  (m_tvalid),
		.ready  (m_tready),
		.held   (held)
	);

	assign m_tdata = {5'd0, held.user_id, held.kind};

endmodule

`default_nettype wire

// File: rtl/core/tcr_parser.sv
`default_nettype none

module tcr_parser #(
	parameter int MAX_LEN = 128
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic [7:0]          char_code,
	input  wire logic                end_of_string,
	output logic                     res_valid,
	output tcr_pkg::tcr_result_t     result
);
	import tcr_pkg::*;

	localparam int SEEN_W = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
	localparam logic [SEEN_W-1:0] SEEN_LIMIT = SEEN_W'(MAX_LEN - 1);

	typedef enum logic [2:0] {
		ST_LEAD   = 3'd0,
		ST_KEY    = 3'd1,
		ST_GAP    = 3'd2,
		ST_PREFIX = 3'd3,
		ST_WS     = 3'd4,
		ST_DIGITS = 3'd5,
		ST_IDEND  = 3'd6,
		ST_DONE   = 3'd7
	} stage_t;

	stage_t              stage_q, stage_d;
	logic [SEEN_W-1:0]   seen_q, seen_d;
	logic [5:0]          cand_q, cand_d;
	logic [2:0]          kpos_q, kpos_d;
	logic [1:0]          ppos_q, ppos_d;
	logic [7:0]          acc_q, acc_d;
	logic                neg_q, neg_d;
	logic                term_q, term_d;

	logic [7:0]  c;
	logic        is_digit;
	logic        is_space;
	logic [3:0]  dval;
	logic [1:0]  ppos_eff;
	logic        proc;
	logic [5:0]  fin_mask;
	logic [7:0]  id_val;

	function automatic logic [5:0] key_match(input logic [5:0] mask, input logic [2:0] pos,
			input logic [7:0] ch);
		logic [5:0] m;
		m = mask;
		for (int k = 0; k < NUM_KW; k++) begin
			if (mask[k] && (pos >= KW_LEN[k] || KW_TEXT[k][{pos, 3'b000} +: 8] != ch))
				m[k] = 1'b0;
		end
		return m;
	endfunction

	function automatic logic [5:0] key_finish(input logic [5:0] mask, input logic [2:0] pos);
		logic [5:0] m;
		m = '0;
		for (int k = 0; k < NUM_KW; k++) begin
			if (mask[k] && KW_LEN[k] == pos)
				m[k] = 1'b1;
		end
		return m;
	endfunction

	function automatic cmd_kind_t kind_of(input logic [5:0] mask);
		cmd_kind_t r;
		r = KIND_UNKNOWN;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (mask[k])
				r = cmd_kind_t'(3'(k + 1));
		end
		return r;
	endfunction

	always_comb begin
		c = char_code;
		if (char_code >= CH_LOW_A && char_code <= CH_LOW_Z)
			c = char_code - CASE_GAP;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		dval = 4'(c - CH_ZERO);
		ppos_eff = (stage_q == ST_GAP) ? 2'd0 : ppos_q;

		stage_d = stage_q;
		seen_d  = seen_q;
		cand_d  = cand_q;
		kpos_d  = kpos_q;
		ppos_d  = ppos_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		term_d  = term_q;
		proc    = 1'b0;

		if (!term_q) begin
			if (char_code == 8'd0 || seen_q == SEEN_LIMIT)
				term_d = 1'b1;
			else begin
				proc = 1'b1;
				seen_d = seen_q + 1'b1;
			end
		end

		if (proc) begin
			case (stage_q)
				ST_LEAD: begin
					if (c != CH_COMMA) begin
						stage_d = ST_KEY;
						cand_d = key_match(6'h3F, 3'd0, c);
						kpos_d = 3'd1;
					end
				end
				ST_KEY: begin
					if (c == CH_COMMA) begin
						cand_d = key_finish(cand_q, kpos_q);
						stage_d = (cand_d[1:0] != 2'b00) ? ST_GAP : ST_DONE;
					end else begin
						cand_d = key_match(cand_q, kpos_q, c);
						if (kpos_q != 3'd7)
							kpos_d = kpos_q + 3'd1;
					end
				end
				ST_GAP, ST_PREFIX: begin
					// a non-comma byte in the gap is checked as the first prefix char
					if (!(stage_q == ST_GAP && c == CH_COMMA)) begin
						if (ppos_eff != 2'd3 && c == ID_PREFIX[{ppos_eff, 3'b000} +: 8]) begin
							if (ppos_eff == 2'd2) begin
								ppos_d = 2'd0;
								stage_d = ST_WS;
							end else begin
								ppos_d = ppos_eff + 2'd1;
								stage_d = ST_PREFIX;
							end
						end else begin
							cand_d = '0;
							stage_d = ST_DONE;
						end
					end
				end
				ST_WS: begin
					if (is_space) begin
						stage_d = ST_WS;
					end else if (c == CH_PLUS || c == CH_MINUS) begin
						neg_d = (c == CH_MINUS);
						stage_d = ST_DIGITS;
					end else if (is_digit) begin
						acc_d = {4'd0, dval};
						stage_d = ST_DIGITS;
					end else begin
						stage_d = ST_IDEND;
					end
				end
				ST_DIGITS: begin
					if (is_digit)
						acc_d = {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0} + {4'd0, dval};
					else
						stage_d = ST_IDEND;
				end
				default: begin
				end
			endcase
		end

		// result is taken from the state after this beat
		fin_mask = key_finish(cand_d, kpos_d);
		id_val = neg_d ? (8'd0 - acc_d) : acc_d;
		result.kind = KIND_UNKNOWN;
		result.user_id = 8'd0;
		case (stage_d)
			ST_KEY: begin
				if (fin_mask[1:0] == 2'b00)
					result.kind = kind_of(fin_mask);
			end
			ST_WS, ST_DIGITS, ST_IDEND: begin
				if (id_val != 8'd0) begin
					result.kind = kind_of(cand_d);
					result.user_id = id_val;
				end
			end
			ST_DONE: result.kind = kind_of(cand_d);
			default: begin
			end
		endcase

		res_valid = take && end_of_string;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= ST_LEAD;
			seen_q  <= '0;
			cand_q  <= 6'h3F;
			kpos_q  <= 3'd0;
			ppos_q  <= 2'd0;
			acc_q   <= 8'd0;
			neg_q   <= 1'b0;
			term_q  <= 1'b0;
		end else if (take) begin
			if (end_of_string) begin
				stage_q <= ST_LEAD;
				seen_q  <= '0;
				cand_q  <= 6'h3F;
				kpos_q  <= 3'd0;
				ppos_q  <= 2'd0;
				acc_q   <= 8'd0;
				neg_q   <= 1'b0;
				term_q  <= 1'b0;
			end else begin
				stage_q <= stage_d;
				seen_q  <= seen_d;
				cand_q  <= cand_d;
				kpos_q  <= kpos_d;
				ppos_q  <= ppos_d;
				acc_q   <= acc_d;
				neg_q   <= neg_d;
				term_q  <= term_d;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/tcr_out_reg.sv
`default_nettype none

module tcr_out_reg (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  tcr_pkg::tcr_result_t       result,
	output logic                       free,
	output logic                       valid,
	input  wire logic                  ready,
	output tcr_pkg::tcr_result_t       held
);
	import tcr_pkg::*;

	logic         valid_q;
	tcr_result_t  held_q;

	// a new beat may enter when the register is empty or the held result leaves this cycle
	assign free  = !valid_q || ready;
	assign valid = valid_q;
	assign held  = held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			held_q <= result;
	end

endmodule

`default_nettype wire
